FILE: design/lfsa_pkg.sv
// shared types, codes and bit helpers for the lowest-free slot allocator
package lfsa_pkg;

	localparam int WORD_W     = 32;
	localparam int BIT_W      = 5;
	localparam int SLOT_W     = 10;
	localparam int MARK_OUT_W = 11;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_FULL         = 2'd1,
		ST_ALREADY_FREE = 2'd2,
		ST_OUT_OF_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		op_t               opcode;
		logic [SLOT_W-1:0] target_slot;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]     slot_index;
		status_t               status;
		logic [MARK_OUT_W-1:0] slots_in_use;
	} rsp_t;

	typedef struct packed {
		logic load_in;
		logic clr_step;
		logic dec_ext;
		logic dec_full;
		logic dec_oor;
		logic a_start;
		logic f_start;
		logic a_step;
		logic f_check;
		logic trim;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic is_free;
		logic cnt_zero;
		logic full;
		logic oor;
		logic hit;
		logic bit_set;
		logic top;
		logic live_any;
		logic row_zero;
		logic clr_last;
	} dp_sts_t;

	// ones in every bit position below n
	function automatic logic [WORD_W-1:0] low_mask(input logic [BIT_W:0] n);
		logic [WORD_W-1:0] m;
		for (int i = 0; i < WORD_W; i++) begin
			m[i] = ((BIT_W+1)'(i) < n);
		end
		return m;
	endfunction

	function automatic logic [BIT_W-1:0] lowest_one(input logic [WORD_W-1:0] w);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

	function automatic logic [BIT_W-1:0] highest_one(input logic [WORD_W-1:0] w);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (w[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

FILE: design/lfsa_dp.sv
// datapath: flag memory, high-water mark, erased count, scan pointer, result registers
module lfsa_dp #(
	parameter int CAPACITY = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lfsa_pkg::req_t    req,
	input  lfsa_pkg::dp_cmd_t cmd,
	output lfsa_pkg::dp_sts_t sts,
	output lfsa_pkg::rsp_t    rsp
);
	import lfsa_pkg::*;

	localparam int ROWS   = (CAPACITY + WORD_W - 1) / WORD_W;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int MARK_W = $clog2(CAPACITY + 1);
	localparam int IDX_W  = ROW_W + BIT_W;
	localparam int EXT_W  = (IDX_W + 1 > MARK_OUT_W) ? IDX_W + 1 : MARK_OUT_W;

	logic [WORD_W-1:0] mem [ROWS];
	logic [WORD_W-1:0] rd_q;

	op_t               op_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ROW_W-1:0]  ptr_q;
	logic [BIT_W:0]    limit_q;
	logic [MARK_W-1:0] mark_q;
	logic [MARK_W-1:0] cnt_q;
	logic [SLOT_W-1:0] res_slot_q;
	status_t           res_status_q;
	rsp_t              rsp_q;

	logic [EXT_W-1:0]  mark_ext;
	logic [EXT_W-1:0]  slot_ext;
	logic [EXT_W-1:0]  ptr_base;
	logic [EXT_W-1:0]  grant_ext;
	logic [ROW_W-1:0]  slot_row;
	logic [BIT_W-1:0]  slot_bit;
	logic [WORD_W-1:0] live;
	logic [BIT_W-1:0]  lo_idx;
	logic [BIT_W-1:0]  hi_idx;
	logic [BIT_W:0]    keep_n;
	logic [BIT_W:0]    drop_n;
	logic              do_trim;
	logic              we;
	logic              re;
	logic [ROW_W-1:0]  wa;
	logic [ROW_W-1:0]  ra;
	logic [WORD_W-1:0] wd;

	assign mark_ext  = EXT_W'(mark_q);
	assign slot_ext  = EXT_W'(slot_q);
	assign slot_row  = slot_ext[BIT_W +: ROW_W];
	assign slot_bit  = slot_q[BIT_W-1:0];
	assign ptr_base  = EXT_W'({ptr_q, {BIT_W{1'b0}}});
	assign lo_idx    = lowest_one(rd_q);
	assign grant_ext = ptr_base + EXT_W'(lo_idx);
	// live slots of the current row below the limit
	assign live      = ~rd_q & low_mask(limit_q);
	assign hi_idx    = highest_one(live);
	assign keep_n    = (BIT_W+1)'(hi_idx) + (BIT_W+1)'(1);
	assign drop_n    = sts.live_any ? (limit_q - keep_n) : limit_q;

	always_comb begin
		sts.is_free  = (op_q == OP_FREE);
		sts.cnt_zero = (cnt_q == '0);
		sts.full     = (mark_ext == EXT_W'(CAPACITY));
		sts.oor      = (slot_ext >= mark_ext);
		sts.top      = ((slot_ext + EXT_W'(1)) == mark_ext);
		sts.hit      = |rd_q;
		sts.bit_set  = rd_q[slot_bit];
		sts.live_any = |live;
		sts.row_zero = (ptr_q == '0);
		sts.clr_last = (ptr_q == ROW_W'(ROWS - 1));
	end

	assign do_trim = cmd.trim | (cmd.f_check & ~sts.bit_set & sts.top);

	always_comb begin
		we = 1'b0;
		wa = ptr_q;
		wd = '0;
		re = 1'b0;
		ra = ptr_q;
		if (cmd.clr_step) begin
			we = 1'b1;
		end
		if (cmd.a_start) begin
			re = 1'b1;
			ra = '0;
		end
		if (cmd.f_start) begin
			re = 1'b1;
			ra = slot_row;
		end
		if (cmd.a_step) begin
			if (sts.hit) begin
				we = 1'b1;
				wd = rd_q & ~(WORD_W'(1) << lo_idx);
			end else begin
				re = 1'b1;
				ra = ptr_q + ROW_W'(1);
			end
		end
		if (cmd.f_check && !sts.bit_set && !sts.top) begin
			we = 1'b1;
			wd = rd_q | (WORD_W'(1) << slot_bit);
		end
		if (do_trim) begin
			// drop erased flags above the new mark within this row
			we = 1'b1;
			wd = sts.live_any ? (rd_q & low_mask(keep_n)) : '0;
			if (!sts.live_any && !sts.row_zero) begin
				re = 1'b1;
				ra = ptr_q - ROW_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			mark_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.clr_step) begin
				ptr_q <= ptr_q + ROW_W'(1);
			end
			if (cmd.a_start) begin
				ptr_q <= '0;
			end
			if (cmd.f_start) begin
				ptr_q <= slot_row;
			end
			if (cmd.dec_ext) begin
				mark_q <= mark_q + MARK_W'(1);
			end
			if (cmd.a_step) begin
				if (sts.hit) begin
					cnt_q <= cnt_q - MARK_W'(1);
				end else begin
					ptr_q <= ptr_q + ROW_W'(1);
				end
			end
			if (cmd.f_check && !sts.bit_set && !sts.top) begin
				cnt_q <= cnt_q + MARK_W'(1);
			end
			if (do_trim) begin
				cnt_q <= MARK_W'(EXT_W'(cnt_q) - EXT_W'(drop_n));
				if (sts.live_any) begin
					mark_q <= MARK_W'(ptr_base + EXT_W'(keep_n));
				end else if (sts.row_zero) begin
					mark_q <= '0;
				end else begin
					ptr_q <= ptr_q - ROW_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= req.opcode;
			slot_q <= req.target_slot;
		end
		if (cmd.f_start) begin
			limit_q <= {1'b0, slot_bit};
		end
		if (do_trim && !sts.live_any && !sts.row_zero) begin
			limit_q <= (BIT_W+1)'(WORD_W);
		end
		if (cmd.dec_ext) begin
			res_slot_q   <= mark_ext[SLOT_W-1:0];
			res_status_q <= ST_OK;
		end
		if (cmd.dec_full) begin
			res_slot_q   <= '0;
			res_status_q <= ST_FULL;
		end
		if (cmd.dec_oor) begin
			res_slot_q   <= slot_q;
			res_status_q <= ST_OUT_OF_RANGE;
		end
		if (cmd.a_step && sts.hit) begin
			res_slot_q   <= grant_ext[SLOT_W-1:0];
			res_status_q <= ST_OK;
		end
		if (cmd.f_check) begin
			res_slot_q   <= slot_q;
			res_status_q <= sts.bit_set ? ST_ALREADY_FREE : ST_OK;
		end
		if (cmd.out_load) begin
			rsp_q.slot_index   <= res_slot_q;
			rsp_q.status       <= res_status_q;
			rsp_q.slots_in_use <= mark_ext[MARK_OUT_W-1:0];
		end
	end

	assign rsp = rsp_q;

endmodule

FILE: design/lfsa_ctrl.sv
// controller: sequences clearing, decode, row scans and result hand-off
module lfsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  lfsa_pkg::dp_sts_t sts,
	output lfsa_pkg::dp_cmd_t cmd
);
	import lfsa_pkg::*;

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_DECODE = 7'b0000100,
		S_ASCAN  = 7'b0001000,
		S_FCHECK = 7'b0010000,
		S_TRIM   = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign out_free  = !out_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (!sts.is_free) begin
					if (!sts.cnt_zero) begin
						cmd.a_start = 1'b1;
						state_d     = S_ASCAN;
					end else if (sts.full) begin
						cmd.dec_full = 1'b1;
						state_d      = S_FINISH;
					end else begin
						cmd.dec_ext = 1'b1;
						state_d     = S_FINISH;
					end
				end else if (sts.oor) begin
					cmd.dec_oor = 1'b1;
					state_d     = S_FINISH;
				end else begin
					cmd.f_start = 1'b1;
					state_d     = S_FCHECK;
				end
			end
			S_ASCAN: begin
				cmd.a_step = 1'b1;
				if (sts.hit) begin
					state_d = S_FINISH;
				end
			end
			S_FCHECK: begin
				cmd.f_check = 1'b1;
				// freeing the top slot walks down while whole rows are erased
				if (!sts.bit_set && sts.top && !sts.live_any && !sts.row_zero) begin
					state_d = S_TRIM;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_TRIM: begin
				cmd.trim = 1'b1;
				if (sts.live_any || sts.row_zero) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/lowest_free_slot_allocator_core.sv
// Lowest-free slot allocator. After reset the block sweeps its erased-flag memory once,
// one 32-slot row per cycle, before the first request is accepted. A request
// transaction is then taken in the idle state and its response is presented from an
// output register, loaded in the finish state once that register is free; the next
// request is accepted while that response waits, and its own response then holds in
// the last state until the output register frees up. An allocate that raises the mark,
// store full and a free out of range are settled in decode; an ordinary free or an
// already-free slot checks one row; an allocate that reuses an erased slot scans rows
// up from row zero to the first erased slot; a free of the top slot with no live slot
// below it in its row trims down through lower rows until it meets a live slot or
// reaches row zero. The scans go one flag-memory row per cycle, read through a single
// registered read port.
module lowest_free_slot_allocator_core #(
	parameter int CAPACITY = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  lfsa_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output lfsa_pkg::rsp_t rsp
);
	import lfsa_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	lfsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lfsa_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

FILE: design/lfsa_checker.sv
// port-level checks for the allocator and their binding to the top level
module lfsa_checker #(
	parameter int CAPACITY = 1024
) (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input lfsa_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input lfsa_pkg::rsp_t rsp
);
	import lfsa_pkg::*;

	localparam logic MARK_FITS = (CAPACITY < 1024);

	// a waiting request transaction holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request changed while waiting");

	// a stalled response transaction holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// store full grants nothing and leaves the mark at capacity
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |->
		rsp.slot_index == '0 &&
		rsp.slots_in_use == MARK_OUT_W'(CAPACITY))
		else $error("store full response inconsistent");

	// out of range means the slot sits at or above the unchanged mark
	a_oor: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_OUT_OF_RANGE && MARK_FITS |->
		MARK_OUT_W'(rsp.slot_index) >= rsp.slots_in_use)
		else $error("out of range slot below mark");

	// an already-free slot lies below the unchanged mark
	a_already: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_ALREADY_FREE && MARK_FITS |->
		MARK_OUT_W'(rsp.slot_index) < rsp.slots_in_use)
		else $error("already free slot at or above mark");

endmodule

bind lowest_free_slot_allocator_core lfsa_checker #(
	.CAPACITY (CAPACITY)
) u_lfsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
